/* rtl/core/tzr_pkg.sv */
// ----------------------------------------------------------------------------
// tzr_pkg
// Shared types and constants for the triangle depth-buffer rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tzr_pkg;

  localparam int unsigned SIDE_DEF = 256;

  localparam int unsigned CRD_W = 12;
  localparam int unsigned DEP_W = 24;
  localparam int unsigned STO_W = 25;

  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_DRAW  = 2'd1;
  localparam logic [1:0] FN_PROBE = 2'd2;
  localparam logic [1:0] FN_RSVD  = 2'd3;

  localparam logic signed [STO_W-1:0] EMPTY_DEPTH = -25'sd16777216;

  // interpolation unit widths
  localparam int unsigned MA_W = 14;
  localparam int unsigned MB_W = 26;
  localparam int unsigned PW   = MA_W + MB_W;
  localparam int unsigned DV_W = 13;
  localparam int unsigned DC_W = $clog2(PW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_PRB,
    ST_PRB_OUT,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_SPAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [CRD_W-1:0]   v0_x;
    logic signed [CRD_W-1:0]   v0_y;
    logic signed [DEP_W-1:0]   v0_z;
    logic signed [CRD_W-1:0]   v1_x;
    logic signed [CRD_W-1:0]   v1_y;
    logic signed [DEP_W-1:0]   v1_z;
    logic signed [CRD_W-1:0]   v2_x;
    logic signed [CRD_W-1:0]   v2_y;
    logic signed [DEP_W-1:0]   v2_z;
  } in_t;

  typedef struct packed {
    logic signed [STO_W-1:0] stored_depth;
    logic                    inside_res;
    logic                    visible;
  } out_t;

endpackage

`default_nettype wire

/* rtl/core/triangle_zbuffer_rasterizer.sv */
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer
// Scanline triangle fill into a SIDE x SIDE depth memory, with clear and probe.
// ----------------------------------------------------------------------------
// Draw solves the edge terms of each row (x and depth of both edges), then
//   an interpolation for each covered pixel; one shared multiply and
//   bit-serial divide unit serves both and sets the pixel cost.
// Throughput: one beat at a time; busy stays high through the result strobe.
// Reset: a clearing pass over all SIDE*SIDE entries fills the memory with the
//   empty mark, busy is high meanwhile. Results cannot be stalled.
`default_nettype none

module triangle_zbuffer_rasterizer #(
  parameter int unsigned SIDE = tzr_pkg::SIDE_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire tzr_pkg::in_t  item_i,
  output logic               res_valid_o,
  output tzr_pkg::out_t      res_o
);
  import tzr_pkg::*;

  localparam int unsigned NENT = SIDE * SIDE;
  localparam int unsigned AW   = $clog2(NENT);
  localparam int unsigned CW   = $clog2(SIDE);
  localparam logic signed [12:0] SIDE_S = 13'(SIDE);
  localparam logic signed [12:0] SMAX_S = 13'(SIDE - 1);

  state_e state_q, state_d;

  logic [AW-1:0]   clr_cnt_q;
  logic            clr_resp_q;
  logic [1:0]      k_q;
  logic            pix_q;
  logic [DC_W-1:0] dcnt_q;

  logic signed [CRD_W-1:0] sx_q [3];
  logic signed [CRD_W-1:0] sy_q [3];
  logic signed [DEP_W-1:0] sz_q [3];
  logic signed [DEP_W-1:0] pz_q;
  logic signed [12:0]      y_q, yhi_q, x_q, xe_q, ax_q, bx_q;
  logic signed [STO_W-1:0] az_q, bz_q, base_q;
  logic [PW-1:0]           num_q;
  logic [DV_W-1:0]         rem_q, d_q;
  logic                    neg_q;
  out_t                    res_q;
  logic [STO_W-1:0]        rdata_q;

  logic [STO_W-1:0] mem [NENT];

  // ---- vertex sort at accept ----
  logic signed [CRD_W-1:0] tx [3];
  logic signed [CRD_W-1:0] ty [3];
  logic signed [DEP_W-1:0] tz [3];
  logic signed [CRD_W-1:0] hx;
  logic signed [CRD_W-1:0] hy;
  logic signed [DEP_W-1:0] hz;

  always_comb begin
    hx = '0; hy = '0; hz = '0;
    tx[0] = item_i.v0_x; ty[0] = item_i.v0_y; tz[0] = item_i.v0_z;
    tx[1] = item_i.v1_x; ty[1] = item_i.v1_y; tz[1] = item_i.v1_z;
    tx[2] = item_i.v2_x; ty[2] = item_i.v2_y; tz[2] = item_i.v2_z;
    if (ty[0] > ty[1]) begin
      hx = tx[0]; tx[0] = tx[1]; tx[1] = hx;
      hy = ty[0]; ty[0] = ty[1]; ty[1] = hy;
      hz = tz[0]; tz[0] = tz[1]; tz[1] = hz;
    end
    if (ty[0] > ty[2]) begin
      hx = tx[0]; tx[0] = tx[2]; tx[2] = hx;
      hy = ty[0]; ty[0] = ty[2]; ty[2] = hy;
      hz = tz[0]; tz[0] = tz[2]; tz[2] = hz;
    end
    if (ty[1] > ty[2]) begin
      hx = tx[1]; tx[1] = tx[2]; tx[2] = hx;
      hy = ty[1]; ty[1] = ty[2]; ty[2] = hy;
      hz = tz[1]; tz[1] = tz[2]; tz[2] = hz;
    end
  end

  logic signed [12:0] ylo, yhi;
  logic               draw_skip;
  logic               accept;
  logic               p_inside;

  assign accept = start && !busy;
  assign ylo = (ty[0] < 0) ? 13'sd0 : 13'(ty[0]);
  assign yhi = (13'(ty[2]) > SMAX_S) ? SMAX_S : 13'(ty[2]);
  assign draw_skip = (ty[2] == ty[0]) || (ylo > yhi);
  assign p_inside = (item_i.v0_x >= 0) && (13'(item_i.v0_x) < SIDE_S) &&
                    (item_i.v0_y >= 0) && (13'(item_i.v0_y) < SIDE_S);

  // ---- interpolation operands ----
  logic signed [MA_W-1:0]  op_a;
  logic signed [MB_W-1:0]  op_b;
  logic signed [12:0]      op_d;
  logic signed [STO_W-1:0] op_base;
  logic                    upper, flat;

  assign upper = y_q < 13'(sy_q[1]);
  assign flat  = sy_q[2] == sy_q[1];

  always_comb begin
    op_a = '0; op_b = '0; op_d = 13'sd1; op_base = '0;
    if (pix_q) begin
      op_a    = MA_W'(x_q) - MA_W'(ax_q);
      op_b    = MB_W'(bz_q) - MB_W'(az_q);
      op_d    = bx_q - ax_q;
      op_base = az_q;
    end else if (!k_q[1]) begin
      op_a    = MA_W'(y_q) - MA_W'(sy_q[0]);
      op_d    = 13'(sy_q[2]) - 13'(sy_q[0]);
      op_b    = k_q[0] ? (MB_W'(sz_q[2]) - MB_W'(sz_q[0]))
                       : (MB_W'(sx_q[2]) - MB_W'(sx_q[0]));
      op_base = k_q[0] ? STO_W'(sz_q[0]) : STO_W'(sx_q[0]);
    end else if (upper) begin
      op_a    = MA_W'(y_q) - MA_W'(sy_q[0]);
      op_d    = 13'(sy_q[1]) - 13'(sy_q[0]);
      op_b    = k_q[0] ? (MB_W'(sz_q[1]) - MB_W'(sz_q[0]))
                       : (MB_W'(sx_q[1]) - MB_W'(sx_q[0]));
      op_base = k_q[0] ? STO_W'(sz_q[0]) : STO_W'(sx_q[0]);
    end else if (flat) begin
      op_base = k_q[0] ? STO_W'(sz_q[1]) : STO_W'(sx_q[1]);
    end else begin
      op_a    = MA_W'(y_q) - MA_W'(sy_q[1]);
      op_d    = 13'(sy_q[2]) - 13'(sy_q[1]);
      op_b    = k_q[0] ? (MB_W'(sz_q[2]) - MB_W'(sz_q[1]))
                       : (MB_W'(sx_q[2]) - MB_W'(sx_q[1]));
      op_base = k_q[0] ? STO_W'(sz_q[1]) : STO_W'(sx_q[1]);
    end
  end

  logic signed [PW-1:0] prod;
  assign prod = PW'(op_a) * PW'(op_b);

  // ---- divider step and finish ----
  logic [DV_W:0]           r2;
  logic                    qbit;
  logic [PW-1:0]           qs;
  logic signed [STO_W-1:0] fin_res;

  assign r2      = {rem_q, num_q[PW-1]};
  assign qbit    = r2 >= {1'b0, d_q};
  assign qs      = neg_q ? (PW'(0) - num_q) : num_q;
  assign fin_res = base_q + $signed(qs[STO_W-1:0]);

  // ---- span setup ----
  logic signed [12:0]      s_ax, s_bx, s_xs, s_xe;
  logic signed [STO_W-1:0] s_az, s_bz;
  logic                    span_ok, last_x, last_y;

  always_comb begin
    if (ax_q > bx_q) begin
      s_ax = bx_q; s_bx = ax_q; s_az = bz_q; s_bz = az_q;
    end else begin
      s_ax = ax_q; s_bx = bx_q; s_az = az_q; s_bz = bz_q;
    end
    s_xs = (s_ax < 0) ? 13'sd0 : s_ax;
    s_xe = (s_bx > SIDE_S) ? SIDE_S : s_bx;
  end

  assign span_ok = s_xs < s_xe;
  assign last_x  = (x_q + 13'sd1) == xe_q;
  assign last_y  = y_q == yhi_q;

  logic [AW-1:0] pix_addr;
  assign pix_addr = AW'(y_q[CW-1:0]) * AW'(SIDE) + AW'(x_q[CW-1:0]);

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.func)
            FN_CLEAR: state_d = ST_CLR;
            FN_DRAW:  state_d = draw_skip ? ST_DONE : ST_MUL;
            FN_PROBE: state_d = p_inside ? ST_PRB : ST_DONE;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        if (clr_cnt_q == AW'(NENT - 1)) state_d = clr_resp_q ? ST_DONE : ST_IDLE;
      end
      ST_PRB:     state_d = ST_PRB_OUT;
      ST_PRB_OUT: state_d = ST_DONE;
      ST_MUL:     state_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == DC_W'(PW - 1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (pix_q) state_d = !last_x ? ST_MUL : (last_y ? ST_DONE : ST_MUL);
        else       state_d = (k_q == 2'd3) ? ST_SPAN : ST_MUL;
      end
      ST_SPAN: state_d = (span_ok || !last_y) ? ST_MUL : ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- outputs and memory controls ----
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [STO_W-1:0]     mem_wdata;

  always_comb begin
    busy        = state_q != ST_IDLE;
    res_valid_o = state_q == ST_DONE;
    res_o       = res_q;
    mem_we      = 1'b0;
    mem_addr    = pix_addr;
    mem_wdata   = fin_res;
    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = EMPTY_DEPTH;
      end
      ST_FIN: mem_we = pix_q && ($signed(rdata_q) < fin_res);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_cnt_q  <= '0;
      clr_resp_q <= 1'b0;
      k_q        <= '0;
      pix_q      <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          clr_cnt_q  <= '0;
          clr_resp_q <= 1'b1;
          k_q        <= '0;
          pix_q      <= 1'b0;
        end
        ST_CLR:  clr_cnt_q <= clr_cnt_q + AW'(1);
        ST_MUL:  dcnt_q <= '0;
        ST_DIV:  dcnt_q <= dcnt_q + DC_W'(1);
        ST_FIN: begin
          if (pix_q) begin
            if (last_x) pix_q <= 1'b0;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_SPAN: pix_q <= span_ok;
        default: ;
      endcase
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        res_q <= '0;
        for (int i = 0; i < 3; i++) begin
          sx_q[i] <= tx[i];
          sy_q[i] <= ty[i];
          sz_q[i] <= tz[i];
        end
        pz_q <= item_i.v0_z;
        if (item_i.func == FN_PROBE) begin
          y_q <= 13'(item_i.v0_y);
          x_q <= 13'(item_i.v0_x);
        end else begin
          y_q <= ylo;
        end
        yhi_q <= yhi;
      end
      ST_PRB_OUT: begin
        res_q.stored_depth <= $signed(rdata_q);
        res_q.inside_res   <= 1'b1;
        res_q.visible      <= STO_W'(pz_q) >= $signed(rdata_q);
      end
      ST_MUL: begin
        neg_q  <= prod[PW-1];
        num_q  <= prod[PW-1] ? (PW'(0) - prod) : prod;
        rem_q  <= '0;
        d_q    <= DV_W'(op_d);
        base_q <= op_base;
      end
      ST_DIV: begin
        rem_q <= qbit ? DV_W'(r2 - {1'b0, d_q}) : r2[DV_W-1:0];
        num_q <= {num_q[PW-2:0], qbit};
      end
      ST_FIN: begin
        if (pix_q) begin
          x_q <= x_q + 13'sd1;
          if (last_x) y_q <= y_q + 13'sd1;
        end else begin
          case (k_q)
            2'd0:    ax_q <= fin_res[12:0];
            2'd1:    az_q <= fin_res;
            2'd2:    bx_q <= fin_res[12:0];
            default: bz_q <= fin_res;
          endcase
        end
      end
      ST_SPAN: begin
        ax_q <= s_ax;
        bx_q <= s_bx;
        az_q <= s_az;
        bz_q <= s_bz;
        x_q  <= s_xs;
        xe_q <= s_xe;
        if (!span_ok) y_q <= y_q + 13'sd1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_vis_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.visible) |-> res_o.inside_res)
    else $error("visible outside the buffer");
  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.inside_res) |-> (res_o.stored_depth == '0))
    else $error("nonzero depth for non-probe result");
`endif

endmodule

`default_nettype wire
